[rtl/core/adaptive_order1_arith_encoder_top_macros.svh]
// Assertion macros for the adaptive order-1 arithmetic encoder.
// Used by the top level; no other dependencies.
`ifndef ADAPTIVE_ORDER1_ARITH_ENCODER_TOP_MACROS_SVH
`define ADAPTIVE_ORDER1_ARITH_ENCODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset
`define AOE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("encoder assertion failed");
// Check that a condition is followed by another in the next cycle
`define AOE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("encoder assertion failed");
`else
`define AOE_ASSERT(lbl, clk, rst, prop)
`define AOE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/aoae_pkg.sv]
// Shared types, constants and helper functions for the arithmetic encoder.
// No dependencies; used by the controller, the datapath and the top level.
package aoae_pkg;

  localparam int MAX_SYMBOLS = 64;
  localparam int SYM_W       = 6;
  localparam int ROW_W       = 7;
  localparam int CNT_W       = 32;
  localparam int FREQ_BITS   = 16;
  localparam int SLICE_W     = FREQ_BITS + 1;
  localparam int DVD_W       = CNT_W + FREQ_BITS;
  localparam int RANGE_W     = CNT_W + 1;
  localparam int PROD_W      = RANGE_W + SLICE_W;
  localparam int STORE_DEPTH = (MAX_SYMBOLS + 1) * MAX_SYMBOLS;
  localparam int ADDR_W      = ROW_W + SYM_W;
  localparam int RESULT_CAP  = 32;
  localparam int CAP_W       = 6;
  localparam int STEP_LIMIT  = 64;
  localparam int STEP_W      = 7;
  localparam int DIV_CNT_W   = 6;

  localparam logic [CNT_W-1:0]   HALF_MARK    = 32'h8000_0000;
  localparam logic [CNT_W-1:0]   QUARTER_MARK = 32'h4000_0000;
  localparam logic [CNT_W-1:0]   ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [ROW_W-1:0]   START_ROW    = 7'd64;
  localparam logic [SLICE_W-1:0] FREQ_SCALE   = 17'h1_0000;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_RANGE,
    ST_MUL_HI,
    ST_APPLY_HI,
    ST_APPLY_LO,
    ST_RENORM,
    ST_WRBACK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic sweep;
    logic div_start_lo;
    logic div_start_hi;
    logic take_hi;
    logic range_ld;
    logic mul_hi;
    logic apply_hi;
    logic apply_lo;
    logic step;
    logic load_held;
    logic push_held;
    logic push_last;
    logic writeback;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic sweep_done;
    logic div_done;
    logic step_emit;
    logic step_pend;
    logic renorm_stop;
    logic emit_full;
    logic held_valid;
    logic out_free;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? ALL_ONES : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    return (a == ALL_ONES) ? a : a + 32'd1;
  endfunction

endpackage

[rtl/core/aoae_datapath.sv]
// Datapath of the arithmetic encoder: count store, row sweep, serial divider,
// interval multiplier, renormalization and result registers. Uses aoae_pkg.
module aoae_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  aoae_pkg::ctrl_cmd_t           cmd,
  output aoae_pkg::dp_status_t          sts,
  input  logic [aoae_pkg::SYM_W-1:0]    symbol,
  input  logic [aoae_pkg::ROW_W-1:0]    table_row,
  input  logic [aoae_pkg::SYM_W-1:0]    table_col,
  input  logic [aoae_pkg::CNT_W-1:0]    count_value,
  input  logic                          cfg_wr_en,
  input  logic [aoae_pkg::ROW_W-1:0]    cfg_wr_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          lead_bit,
  output logic [aoae_pkg::CNT_W-1:0]    follow_count,
  output logic                          last
);

  // configuration and clamped row width
  logic [aoae_pkg::ROW_W-1:0] cfg_syms;
  logic [aoae_pkg::ROW_W-1:0] n_eff;

  // item registers
  logic [aoae_pkg::SYM_W-1:0] sym_q;
  logic [aoae_pkg::ROW_W-1:0] n_q;
  logic [aoae_pkg::ROW_W-1:0] ctx;

  // row sweep
  logic [aoae_pkg::ROW_W-1:0] sweep_idx;
  logic                       rd_valid;
  logic [aoae_pkg::SYM_W-1:0] rd_idx;
  logic                       rd_en;
  logic [aoae_pkg::CNT_W-1:0] total;
  logic [aoae_pkg::CNT_W-1:0] cum;
  logic [aoae_pkg::CNT_W-1:0] cnt_sym;

  // count store
  logic [aoae_pkg::CNT_W-1:0]  store [aoae_pkg::STORE_DEPTH];
  logic [aoae_pkg::CNT_W-1:0]  mem_dout;
  logic [aoae_pkg::ADDR_W-1:0] rd_addr;
  logic                        wr_en;
  logic [aoae_pkg::ADDR_W-1:0] wr_addr;
  logic [aoae_pkg::CNT_W-1:0]  wr_data;

  // divider
  logic [aoae_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [aoae_pkg::CNT_W-1:0]     rem;
  logic [aoae_pkg::CNT_W:0]       rem_sh;
  logic [aoae_pkg::DVD_W-1:0]     dvd;
  logic [aoae_pkg::SLICE_W-1:0]   quo;
  logic [aoae_pkg::CNT_W-1:0]     divisor;
  logic [aoae_pkg::SLICE_W-1:0]   s_lo;
  logic [aoae_pkg::SLICE_W-1:0]   s_hi;
  logic                           last_sym;

  // interval arithmetic
  logic [aoae_pkg::RANGE_W-1:0] range_q;
  logic [aoae_pkg::SLICE_W-1:0] mul_op;
  logic [aoae_pkg::PROD_W-1:0]  prod_q;
  logic [aoae_pkg::CNT_W-1:0]   low;
  logic [aoae_pkg::CNT_W-1:0]   high;
  logic [aoae_pkg::CNT_W-1:0]   pending;

  // renormalization
  logic                        c_low0;
  logic                        c_high1;
  logic                        c_mid;
  logic                        step_emit;
  logic                        step_pend;
  logic [aoae_pkg::STEP_W-1:0] steps;
  logic [aoae_pkg::CAP_W-1:0]  emit_cnt;
  logic                        emit_full;

  // held result and output register
  logic                       held_valid;
  logic                       held_lead;
  logic [aoae_pkg::CNT_W-1:0] held_follow;
  logic                       out_free;

  // hold the row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_syms <= aoae_pkg::ROW_W'(aoae_pkg::MAX_SYMBOLS);
    end else if (cfg_wr_en) begin
      cfg_syms <= cfg_wr_data;
    end
  end

  // clamp the row width to one through the table width
  always_comb begin
    if (cfg_syms == '0) begin
      n_eff = aoae_pkg::ROW_W'(1);
    end else if (cfg_syms > aoae_pkg::ROW_W'(aoae_pkg::MAX_SYMBOLS)) begin
      n_eff = aoae_pkg::ROW_W'(aoae_pkg::MAX_SYMBOLS);
    end else begin
      n_eff = cfg_syms;
    end
  end

  assign rd_en    = cmd.sweep && (sweep_idx < n_q);
  assign rd_addr  = {ctx, sweep_idx[aoae_pkg::SYM_W-1:0]};
  assign last_sym = ({1'b0, sym_q} + aoae_pkg::ROW_W'(1)) == n_q;

  // select the store write: a load request or the count update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {table_row, table_col};
    wr_data = count_value;
    if (cmd.load && (table_row <= aoae_pkg::START_ROW)) begin
      wr_en = 1'b1;
    end else if (cmd.writeback) begin
      wr_en   = 1'b1;
      wr_addr = {ctx, sym_q};
      wr_data = aoae_pkg::sat_inc(cnt_sym);
    end
  end

  // count store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_dout <= store[rd_addr];
    end
  end

  // sweep the context row: total, prefix sum and the symbol's count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.start) begin
      sweep_idx <= '0;
      total     <= '0;
      cum       <= '0;
      rd_valid  <= 1'b0;
      sym_q     <= symbol;
      n_q       <= n_eff;
    end else begin
      rd_valid <= rd_en;
      rd_idx   <= sweep_idx[aoae_pkg::SYM_W-1:0];
      if (rd_en) begin
        sweep_idx <= sweep_idx + aoae_pkg::ROW_W'(1);
      end
      if (rd_valid) begin
        total <= aoae_pkg::sat_add(total, mem_dout);
        if (rd_idx < sym_q) begin
          cum <= aoae_pkg::sat_add(cum, mem_dout);
        end
        if (rd_idx == sym_q) begin
          cnt_sym <= mem_dout;
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem, dvd[aoae_pkg::DVD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= aoae_pkg::DIV_CNT_W'(aoae_pkg::DVD_W);
    end else if (cmd.div_start_lo) begin
      divisor <= (total == '0) ? aoae_pkg::CNT_W'(1) : total;
      dvd     <= {cum, {aoae_pkg::FREQ_BITS{1'b0}}};
      rem     <= '0;
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_start_hi) begin
      s_lo    <= quo;
      dvd     <= {aoae_pkg::sat_add(cum, cnt_sym), {aoae_pkg::FREQ_BITS{1'b0}}};
      rem     <= '0;
      quo     <= '0;
      div_cnt <= '0;
    end else if (div_cnt != aoae_pkg::DIV_CNT_W'(aoae_pkg::DVD_W)) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= aoae_pkg::CNT_W'(rem_sh - {1'b0, divisor});
        quo <= {quo[aoae_pkg::SLICE_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[aoae_pkg::CNT_W-1:0];
        quo <= {quo[aoae_pkg::SLICE_W-2:0], 1'b0};
      end
      dvd     <= {dvd[aoae_pkg::DVD_W-2:0], 1'b0};
      div_cnt <= div_cnt + aoae_pkg::DIV_CNT_W'(1);
    end
  end

  // latch the upper slice bound; the last symbol takes the full scale
  always_ff @(posedge clk) begin
    if (cmd.take_hi) begin
      s_hi <= last_sym ? aoae_pkg::FREQ_SCALE : quo;
    end
  end

  // range and the shared multiplier
  assign mul_op = cmd.mul_hi ? s_hi : s_lo;

  always_ff @(posedge clk) begin
    if (cmd.range_ld) begin
      range_q <= {1'b0, high - low} + aoae_pkg::RANGE_W'(1);
    end
    if (cmd.mul_hi || cmd.apply_hi) begin
      prod_q <= range_q * mul_op;
    end
  end

  // renormalization step decode
  assign c_low0    = !high[aoae_pkg::CNT_W-1];
  assign c_high1   = low[aoae_pkg::CNT_W-1];
  assign c_mid     = (low[aoae_pkg::CNT_W-1 -: 2] == 2'b01) &&
                     (high[aoae_pkg::CNT_W-1 -: 2] == 2'b10);
  assign step_emit = (steps != aoae_pkg::STEP_W'(aoae_pkg::STEP_LIMIT)) &&
                     (c_low0 || c_high1);
  assign step_pend = (steps != aoae_pkg::STEP_W'(aoae_pkg::STEP_LIMIT)) &&
                     !(c_low0 || c_high1) && c_mid;
  assign emit_full = emit_cnt == aoae_pkg::CAP_W'(aoae_pkg::RESULT_CAP);

  // interval, pending count and context
  always_ff @(posedge clk) begin
    if (rst) begin
      low     <= '0;
      high    <= aoae_pkg::ALL_ONES;
      pending <= '0;
      ctx     <= aoae_pkg::START_ROW;
    end else if (cmd.flush) begin
      low     <= '0;
      high    <= aoae_pkg::ALL_ONES;
      pending <= '0;
      ctx     <= aoae_pkg::START_ROW;
    end else if (cmd.apply_hi) begin
      high <= low + prod_q[aoae_pkg::FREQ_BITS +: aoae_pkg::CNT_W] - 32'd1;
    end else if (cmd.apply_lo) begin
      low <= low + prod_q[aoae_pkg::FREQ_BITS +: aoae_pkg::CNT_W];
    end else if (cmd.step && step_emit) begin
      pending <= '0;
      low     <= {low[aoae_pkg::CNT_W-2:0], 1'b0};
      high    <= {high[aoae_pkg::CNT_W-2:0], 1'b1};
    end else if (cmd.step && step_pend) begin
      pending <= aoae_pkg::sat_inc(pending);
      low     <= (low - aoae_pkg::QUARTER_MARK) << 1;
      high    <= ((high - aoae_pkg::QUARTER_MARK) << 1) | 32'd1;
    end else if (cmd.writeback) begin
      ctx <= {1'b0, sym_q};
    end
  end

  // step and emission counters
  always_ff @(posedge clk) begin
    if (rst) begin
      steps    <= '0;
      emit_cnt <= '0;
    end else if (cmd.start) begin
      steps    <= '0;
      emit_cnt <= '0;
    end else if (cmd.step) begin
      steps <= steps + aoae_pkg::STEP_W'(1);
      if (step_emit && !emit_full) begin
        emit_cnt <= emit_cnt + aoae_pkg::CAP_W'(1);
      end
    end
  end

  // hold one emission back until the next one shows whether it is the last
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.load_held) begin
      held_valid  <= 1'b1;
      held_lead   <= c_high1 && !c_low0;
      held_follow <= pending;
    end else if (cmd.push_held) begin
      held_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_held) begin
      out_valid    <= 1'b1;
      lead_bit     <= held_lead;
      follow_count <= held_follow;
      last         <= cmd.push_last;
    end else if (cmd.flush) begin
      out_valid    <= 1'b1;
      lead_bit     <= low >= aoae_pkg::QUARTER_MARK;
      follow_count <= aoae_pkg::sat_inc(pending);
      last         <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // status back to the controller
  always_comb begin
    sts.sym_ok      = {1'b0, symbol} < n_eff;
    sts.sweep_done  = (sweep_idx == n_q) && !rd_valid;
    sts.div_done    = div_cnt == aoae_pkg::DIV_CNT_W'(aoae_pkg::DVD_W);
    sts.step_emit   = step_emit;
    sts.step_pend   = step_pend;
    sts.renorm_stop = !step_emit && !step_pend;
    sts.emit_full   = emit_full;
    sts.held_valid  = held_valid;
    sts.out_free    = out_free;
  end

endmodule

[rtl/core/aoae_ctrl.sv]
// Controller state machine of the arithmetic encoder.
// Sequences the datapath through commands; uses aoae_pkg.
module aoae_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           kind,
  input  aoae_pkg::dp_status_t sts,
  output aoae_pkg::ctrl_cmd_t  cmd,
  output logic                 in_stall
);

  aoae_pkg::state_t state;
  aoae_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aoae_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != aoae_pkg::ST_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      aoae_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (aoae_pkg::kind_t'(kind))
            aoae_pkg::KIND_LOAD: begin
              cmd.load = 1'b1;
            end
            aoae_pkg::KIND_ENCODE: begin
              if (sts.sym_ok) begin
                cmd.start  = 1'b1;
                state_next = aoae_pkg::ST_SWEEP;
              end
            end
            aoae_pkg::KIND_FLUSH: begin
              state_next = aoae_pkg::ST_FLUSH;
            end
            default: begin
              // drop unknown requests
            end
          endcase
        end
      end
      aoae_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          cmd.div_start_lo = 1'b1;
          state_next       = aoae_pkg::ST_DIV_LO;
        end
      end
      aoae_pkg::ST_DIV_LO: begin
        if (sts.div_done) begin
          cmd.div_start_hi = 1'b1;
          state_next       = aoae_pkg::ST_DIV_HI;
        end
      end
      aoae_pkg::ST_DIV_HI: begin
        if (sts.div_done) begin
          cmd.take_hi = 1'b1;
          state_next  = aoae_pkg::ST_RANGE;
        end
      end
      aoae_pkg::ST_RANGE: begin
        cmd.range_ld = 1'b1;
        state_next   = aoae_pkg::ST_MUL_HI;
      end
      aoae_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = aoae_pkg::ST_APPLY_HI;
      end
      aoae_pkg::ST_APPLY_HI: begin
        cmd.apply_hi = 1'b1;
        state_next   = aoae_pkg::ST_APPLY_LO;
      end
      aoae_pkg::ST_APPLY_LO: begin
        cmd.apply_lo = 1'b1;
        state_next   = aoae_pkg::ST_RENORM;
      end
      aoae_pkg::ST_RENORM: begin
        if (sts.renorm_stop) begin
          // release the held emission as the last one
          if (!sts.held_valid) begin
            state_next = aoae_pkg::ST_WRBACK;
          end else if (sts.out_free) begin
            cmd.push_held = 1'b1;
            cmd.push_last = 1'b1;
            state_next    = aoae_pkg::ST_WRBACK;
          end
        end else if (sts.step_pend || sts.emit_full) begin
          cmd.step = 1'b1;
        end else if (!sts.held_valid) begin
          cmd.load_held = 1'b1;
          cmd.step      = 1'b1;
        end else if (sts.out_free) begin
          cmd.push_held = 1'b1;
          cmd.load_held = 1'b1;
          cmd.step      = 1'b1;
        end
      end
      aoae_pkg::ST_WRBACK: begin
        cmd.writeback = 1'b1;
        state_next    = aoae_pkg::ST_IDLE;
      end
      aoae_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = aoae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aoae_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/adaptive_order1_arith_encoder_top.sv]
// Load request: taken in the idle state. Flush request: waits in the flush state
// until the output register is free. Encode request: row sweep, serial division for
// the lower then the upper slice bound, interval multiply, up to 64 renormalization
// steps (held by output stalls), the end of renormalization and the count write.
// Reset is synchronous: interval, pending count, context and row width return
// to their initial values; the count store holds no reset and must be loaded.
`include "adaptive_order1_arith_encoder_top_macros.svh"
module adaptive_order1_arith_encoder_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 kind,
  input  logic [aoae_pkg::SYM_W-1:0] symbol,
  input  logic [aoae_pkg::ROW_W-1:0] table_row,
  input  logic [aoae_pkg::SYM_W-1:0] table_col,
  input  logic [aoae_pkg::CNT_W-1:0] count_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       lead_bit,
  output logic [aoae_pkg::CNT_W-1:0] follow_count,
  output logic                       last,
  input  logic                       cfg_wr_en,
  input  logic [aoae_pkg::ROW_W-1:0] cfg_wr_data
);

  aoae_pkg::ctrl_cmd_t  cmd;
  aoae_pkg::dp_status_t sts;

  aoae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  aoae_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .symbol       (symbol),
    .table_row    (table_row),
    .table_col    (table_col),
    .count_value  (count_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .lead_bit     (lead_bit),
    .follow_count (follow_count),
    .last         (last)
  );

  // no emission may stay held once the encoder takes requests again
  `AOE_ASSERT(a_held_clear_idle, clk, rst, !in_stall |-> !sts.held_valid)
  // results enter the output register only when it is free
  `AOE_ASSERT(a_push_free, clk, rst, (cmd.push_held || cmd.flush) |-> sts.out_free)
  // a flush request blocks the input until its result is written
  `AOE_ASSERT_NEXT(a_flush_blocks, clk, rst,
                   in_valid && !in_stall && kind == aoae_pkg::KIND_FLUSH, in_stall)

endmodule

[tb/aoae_checker.sv]
// Checker for the adaptive order-1 arithmetic encoder: watches the request and
// emission channels and the width register, predicts emissions, compares them.
// Depends on aoae_pkg for widths, marks and request kinds.
`timescale 1ns / 1ps
module aoae_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 kind,
  input  logic [aoae_pkg::SYM_W-1:0] symbol,
  input  logic [aoae_pkg::ROW_W-1:0] table_row,
  input  logic [aoae_pkg::SYM_W-1:0] table_col,
  input  logic [aoae_pkg::CNT_W-1:0] count_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       lead_bit,
  input  logic [aoae_pkg::CNT_W-1:0] follow_count,
  input  logic                       last,
  input  logic                       cfg_wr_en,
  input  logic [aoae_pkg::ROW_W-1:0] cfg_wr_data,
  output int                         errors,
  output int                         owed_count
);

  typedef struct packed {
    logic                       lead;
    logic [aoae_pkg::CNT_W-1:0] follow;
    logic                       fin;
  } emission_t;

  emission_t                  owed[$];
  logic [aoae_pkg::CNT_W-1:0] counts [0:aoae_pkg::STORE_DEPTH-1];
  logic [aoae_pkg::CNT_W-1:0] lo_q, hi_q, pend_q;
  logic [aoae_pkg::ROW_W-1:0] ctx_q, width_q;
  int                         emitted;

  assign owed_count = owed.size();

  function automatic logic [aoae_pkg::CNT_W-1:0] add_clamped(
      input logic [aoae_pkg::CNT_W-1:0] a, input logic [aoae_pkg::CNT_W-1:0] b);
    logic [aoae_pkg::CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[aoae_pkg::CNT_W] ? aoae_pkg::ALL_ONES : s[aoae_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [aoae_pkg::CNT_W-1:0] inc_clamped(
      input logic [aoae_pkg::CNT_W-1:0] a);
    return (a == aoae_pkg::ALL_ONES) ? a : a + 32'd1;
  endfunction

  // Queue one emission, dropping any beyond the per-request cap
  task automatic owe(input logic lead, input logic [aoae_pkg::CNT_W-1:0] follow);
    emission_t e;
    if (emitted < aoae_pkg::RESULT_CAP) begin
      e.lead = lead;
      e.follow = follow;
      e.fin = 1'b0;
      owed.push_back(e);
      emitted++;
    end
  endtask

  // Narrow the interval for one symbol, renormalize and adapt its count
  task automatic encode_symbol(input logic [aoae_pkg::SYM_W-1:0] sym);
    int unsigned                n, base, j;
    logic [aoae_pkg::CNT_W-1:0] total, cum, s_lo, s_hi;
    longint unsigned            dv, span;
    n = (width_q == 0) ? 1 :
        (width_q > aoae_pkg::MAX_SYMBOLS) ? aoae_pkg::MAX_SYMBOLS : width_q;
    if (sym >= n) return;
    base = ctx_q * aoae_pkg::MAX_SYMBOLS;
    total = 0;
    cum = 0;
    for (j = 0; j < n; j++) total = add_clamped(total, counts[base + j]);
    for (j = 0; j < sym; j++) cum = add_clamped(cum, counts[base + j]);
    dv = (total == 0) ? 1 : total;
    s_lo = 32'((longint'(cum) * 65536) / dv);
    if (sym + 1 == n) s_hi = 32'h1_0000;
    else s_hi = 32'((longint'(add_clamped(cum, counts[base + sym])) * 65536) / dv);
    span = longint'(hi_q - lo_q) + 1;
    hi_q = lo_q + 32'((span * s_hi) / 65536) - 32'd1;
    lo_q = lo_q + 32'((span * s_lo) / 65536);
    // Renormalize: shift out settled bits, count underflow bits
    for (j = 0; j < aoae_pkg::STEP_LIMIT; j++) begin
      if (hi_q < aoae_pkg::HALF_MARK) begin
        owe(1'b0, pend_q);
        pend_q = 0;
        lo_q = lo_q << 1;
        hi_q = (hi_q << 1) | 32'd1;
      end else if (lo_q >= aoae_pkg::HALF_MARK) begin
        owe(1'b1, pend_q);
        pend_q = 0;
        lo_q = (lo_q - aoae_pkg::HALF_MARK) << 1;
        hi_q = ((hi_q - aoae_pkg::HALF_MARK) << 1) | 32'd1;
      end else if (lo_q >= aoae_pkg::QUARTER_MARK &&
                   hi_q < (aoae_pkg::HALF_MARK | aoae_pkg::QUARTER_MARK)) begin
        pend_q = inc_clamped(pend_q);
        lo_q = (lo_q - aoae_pkg::QUARTER_MARK) << 1;
        hi_q = ((hi_q - aoae_pkg::QUARTER_MARK) << 1) | 32'd1;
      end else begin
        break;
      end
    end
    counts[base + sym] = inc_clamped(counts[base + sym]);
    ctx_q = {1'b0, sym};
  endtask

  // Predict the emissions of one accepted request
  task automatic predict_request();
    emission_t e;
    emitted = 0;
    case (kind)
      aoae_pkg::KIND_LOAD: begin
        if (table_row <= aoae_pkg::START_ROW)
          counts[table_row * aoae_pkg::MAX_SYMBOLS + table_col] = count_value;
      end
      aoae_pkg::KIND_ENCODE: encode_symbol(symbol);
      aoae_pkg::KIND_FLUSH: begin
        owe((lo_q < aoae_pkg::QUARTER_MARK) ? 1'b0 : 1'b1, inc_clamped(pend_q));
        lo_q = 0;
        hi_q = aoae_pkg::ALL_ONES;
        pend_q = 0;
        ctx_q = aoae_pkg::START_ROW;
      end
      default: ;
    endcase
    if (emitted > 0) begin
      e = owed.pop_back();
      e.fin = 1'b1;
      owed.push_back(e);
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      lo_q <= 0;
      hi_q <= aoae_pkg::ALL_ONES;
      pend_q <= 0;
      ctx_q <= aoae_pkg::START_ROW;
      width_q <= 7'd64;
    end else begin
      // Compare an accepted emission with the oldest prediction
      if (out_valid && !out_stall) begin
        if (owed.size() == 0) begin
          $error("unexpected emission lead_bit=%0d follow_count=%0d", lead_bit,
                 follow_count);
          errors++;
        end else begin
          emission_t e;
          e = owed.pop_front();
          if (lead_bit !== e.lead) begin
            $error("lead_bit expected %0d actual %0d", e.lead, lead_bit);
            errors++;
          end
          if (follow_count !== e.follow) begin
            $error("follow_count expected %0d actual %0d", e.follow, follow_count);
            errors++;
          end
          if (last !== e.fin) begin
            $error("last expected %0d actual %0d", e.fin, last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) predict_request();
      if (cfg_wr_en) width_q = cfg_wr_data;
    end
  end
endmodule

[tb/testbench.sv]
// Top of the encoder testbench: clock, reset, request and emission stimulus,
// width register writes and the verdict. Depends on aoae_pkg, aoae_checker, the DUT.
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] KIND_NONE  = 2'd3;
  localparam int         SETTLE     = 400;
  localparam int         SMALL_ROWS = 10;
  localparam int         PHASE_REQS = 18;
  localparam int         WIDE_PAIRS = 5;

  logic                       clk, rst;
  logic                       in_valid, in_stall, out_valid, out_stall;
  logic [1:0]                 kind;
  logic [aoae_pkg::SYM_W-1:0] symbol, table_col;
  logic [aoae_pkg::ROW_W-1:0] table_row, cfg_wr_data;
  logic [aoae_pkg::CNT_W-1:0] count_value, follow_count;
  logic                       lead_bit, last, cfg_wr_en;
  int                         errors, owed_count, taken;
  int unsigned                width_now;

  adaptive_order1_arith_encoder_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .symbol(symbol), .table_row(table_row), .table_col(table_col),
    .count_value(count_value), .out_valid(out_valid), .out_stall(out_stall),
    .lead_bit(lead_bit), .follow_count(follow_count), .last(last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  aoae_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .symbol(symbol), .table_row(table_row), .table_col(table_col),
    .count_value(count_value), .out_valid(out_valid), .out_stall(out_stall),
    .lead_bit(lead_bit), .follow_count(follow_count), .last(last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .errors(errors), .owed_count(owed_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Draw a wait, with runs of back-to-back traffic
  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send(input logic [1:0] k, input logic [aoae_pkg::SYM_W-1:0] s,
                      input logic [aoae_pkg::ROW_W-1:0] r,
                      input logic [aoae_pkg::SYM_W-1:0] c,
                      input logic [aoae_pkg::CNT_W-1:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    symbol <= s;
    table_row <= r;
    table_col <= c;
    count_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic encode(input logic [aoae_pkg::SYM_W-1:0] s);
    send(aoae_pkg::KIND_ENCODE, s, 7'd0, 6'd0, 32'd0);
  endtask

  task automatic flush_req();
    send(aoae_pkg::KIND_FLUSH, 6'd0, 7'd0, 6'd0, 32'd0);
  endtask

  // Drain all predicted emissions, then let a silent encode finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_width(input logic [aoae_pkg::ROW_W-1:0] w);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_now = (w == 0) ? 1 : (w > aoae_pkg::MAX_SYMBOLS) ? aoae_pkg::MAX_SYMBOLS : w;
  endtask

  function automatic logic [aoae_pkg::CNT_W-1:0] draw_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2: return aoae_pkg::ALL_ONES;
      default: return aoae_pkg::CNT_W'($urandom_range(1, 40));
    endcase
  endfunction

  // One random request, mostly in-range encodes
  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      send(aoae_pkg::KIND_ENCODE, aoae_pkg::SYM_W'($urandom_range(0, width_now - 1)),
           aoae_pkg::ROW_W'($urandom()), aoae_pkg::SYM_W'($urandom()), $urandom());
    else if (pick < 74)
      send(aoae_pkg::KIND_ENCODE, aoae_pkg::SYM_W'($urandom_range(0, 63)),
           aoae_pkg::ROW_W'($urandom()), aoae_pkg::SYM_W'($urandom()), $urandom());
    else if (pick < 84)
      send(aoae_pkg::KIND_LOAD, aoae_pkg::SYM_W'($urandom()),
           aoae_pkg::ROW_W'($urandom_range(0, 64)),
           aoae_pkg::SYM_W'($urandom_range(0, 63)), draw_count());
    else if (pick < 86)
      send(aoae_pkg::KIND_LOAD, aoae_pkg::SYM_W'($urandom()),
           aoae_pkg::ROW_W'($urandom_range(65, 127)),
           aoae_pkg::SYM_W'($urandom_range(0, 63)), $urandom());
    else if (pick < 95)
      send(aoae_pkg::KIND_FLUSH, aoae_pkg::SYM_W'($urandom()),
           aoae_pkg::ROW_W'($urandom()), aoae_pkg::SYM_W'($urandom()), $urandom());
    else
      send(KIND_NONE, aoae_pkg::SYM_W'($urandom()), aoae_pkg::ROW_W'($urandom()),
           aoae_pkg::SYM_W'($urandom()), $urandom());
  endtask

  // Emission side: random stalls and one long hold-off
  initial begin
    int gap;
    out_stall = 1'b1;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = (taken == 20) ? 3000 : draw_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Bound the run
  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [aoae_pkg::ROW_W-1:0] small_widths [6];
    logic [aoae_pkg::ROW_W-1:0] wide_widths [2];
    int r, c;
    small_widths = '{7'd10, 7'd1, 7'd2, 7'd0, 7'd5, 7'd8};
    wide_widths = '{7'd64, 7'd127};
    rst = 1'b1;
    in_valid = 1'b0;
    kind = aoae_pkg::KIND_LOAD;
    symbol = 0;
    table_row = 0;
    table_col = 0;
    count_value = 0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 7'd64;
    width_now = 64;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the start row and the low corner: row 7 saturates its sums, row 9 is empty
    for (c = 0; c < aoae_pkg::MAX_SYMBOLS; c++)
      send(aoae_pkg::KIND_LOAD, 6'd0, aoae_pkg::START_ROW, aoae_pkg::SYM_W'(c),
           draw_count());
    for (r = 0; r < SMALL_ROWS; r++)
      for (c = 0; c < SMALL_ROWS; c++)
        send(aoae_pkg::KIND_LOAD, 6'd0, aoae_pkg::ROW_W'(r), aoae_pkg::SYM_W'(c),
             (r == 7) ? aoae_pkg::ALL_ONES : (r == 9) ? '0 : draw_count());

    // Directed requests: full-width start row first
    encode(6'd63);
    flush_req();
    encode(6'd0);
    flush_req();
    set_width(7'd10);
    encode(6'd7);
    encode(6'd9);
    encode(6'd3);
    encode(6'd9);
    flush_req();
    send(KIND_NONE, 6'd63, 7'd127, 6'd63, aoae_pkg::ALL_ONES);
    send(aoae_pkg::KIND_LOAD, 6'd0, 7'd127, 6'd63, aoae_pkg::ALL_ONES);
    send(aoae_pkg::KIND_LOAD, 6'd0, aoae_pkg::START_ROW, 6'd0, 32'd0);
    encode(6'd0);
    send(aoae_pkg::KIND_LOAD, 6'd0, aoae_pkg::START_ROW, 6'd9, aoae_pkg::ALL_ONES);
    flush_req();
    encode(6'd9);
    encode(6'd5);
    encode(6'd5);
    flush_req();
    set_width(7'd1);
    encode(6'd0);
    encode(6'd5);
    flush_req();
    set_width(7'd127);
    encode(6'd63);
    flush_req();

    // Random phases over narrow rows
    foreach (small_widths[i]) begin
      set_width(small_widths[i]);
      repeat (PHASE_REQS) random_request();
    end

    // Wide rows: each encode starts from the start row
    flush_req();
    foreach (wide_widths[i]) begin
      set_width(wide_widths[i]);
      repeat (WIDE_PAIRS) begin
        encode(aoae_pkg::SYM_W'($urandom_range(0, 63)));
        flush_req();
      end
    end

    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
